@@ sv/lsc_pkg.sv @@
// Shared types, widths and helpers for the line segment window clipper.
`timescale 1ns / 1ps

package lsc_pkg;

   // Coordinate width and derived arithmetic widths
   localparam int CW = 16;               // coordinate width
   localparam int DW = CW + 1;           // differences and magnitudes
   localparam int PW = 2 * DW;           // products
   localparam int DIV_STEP = 4;          // quotient bits resolved per divider stage
   localparam int DIV_STAGES = (DW + DIV_STEP - 1) / DIV_STEP;
   localparam int QW = DIV_STEP * DIV_STAGES;   // quotient width, at least DW

   // Control register indexes
   localparam logic [1:0] CSR_LEFT   = 2'd0;
   localparam logic [1:0] CSR_BOTTOM = 2'd1;
   localparam logic [1:0] CSR_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_TOP    = 2'd3;

   // Window reset corners
   localparam logic signed [CW-1:0] WIN_LOW_RESET  = '0;
   localparam logic signed [CW-1:0] WIN_HIGH_RESET = CW'(32767);

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                 visible;
      logic signed [CW-1:0] clipped_start_x;
      logic signed [CW-1:0] clipped_start_y;
      logic signed [CW-1:0] clipped_end_x;
      logic signed [CW-1:0] clipped_end_y;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] left;
      logic signed [CW-1:0] bottom;
      logic signed [CW-1:0] right;
      logic signed [CW-1:0] top;
   } window_type;

   // Entry/exit candidates of one axis
   typedef struct packed {
      logic          reject;
      logic          neg;
      logic [DW-1:0] mag;
      logic [DW-1:0] en_num;
      logic [DW-1:0] en_den;
      logic [DW-1:0] ex_num;
      logic [DW-1:0] ex_den;
   } axis_type;

   // Parameter unit result: chosen entry and exit fractions
   typedef struct packed {
      logic          valid;
      logic          reject;
      logic [DW-1:0] en_num;
      logic [DW-1:0] en_den;
      logic [DW-1:0] ex_num;
      logic [DW-1:0] ex_den;
      logic [DW-1:0] mag_x;
      logic [DW-1:0] mag_y;
      logic          neg_x;
      logic          neg_y;
      req_type       item;
   } frac_type;

   // Side data that rides along the divider pipeline
   typedef struct packed {
      logic    valid;
      logic    reject;
      logic    neg_x;
      logic    neg_y;
      req_type item;
   } side_type;

   function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
      return {v[CW-1], v};
   endfunction

   // base plus or minus the truncated offset, wrapped to coordinate width
   function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] base,
                                                  input logic neg,
                                                  input logic [QW-1:0] off);
      logic signed [DW-1:0] sum;
      if (neg) begin
         sum = sx(base) - off[DW-1:0];
      end else begin
         sum = sx(base) + off[DW-1:0];
      end
      return sum[CW-1:0];
   endfunction

endpackage

@@ sv/line_segment_window_clip.sv @@
// Top level: window registers, fraction products, dividers and result register.
// Pipeline: 4 parameter stages, 1 product stage, 5 divider stages at 4 quotient bits
// each, 1 result register.
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous; clears all valid bits and loads the window to (0,0)-(32767,32767).
`timescale 1ns / 1ps

module line_segment_window_clip (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lsc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lsc_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [lsc_pkg::CW-1:0] csr_data
);

   logic pipe_en;
   logic rsp_valid_ff;

   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;

   // Window registers
   lsc_pkg::window_type win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= lsc_pkg::WIN_LOW_RESET;
         win_ff.bottom <= lsc_pkg::WIN_LOW_RESET;
         win_ff.right  <= lsc_pkg::WIN_HIGH_RESET;
         win_ff.top    <= lsc_pkg::WIN_HIGH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lsc_pkg::CSR_LEFT:   win_ff.left   <= csr_data;
            lsc_pkg::CSR_BOTTOM: win_ff.bottom <= csr_data;
            lsc_pkg::CSR_RIGHT:  win_ff.right  <= csr_data;
            lsc_pkg::CSR_TOP:    win_ff.top    <= csr_data;
            default: ;
         endcase
      end
   end

   // Entry and exit parameters
   lsc_pkg::frac_type frac;

   lsc_param u_param (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (req_valid),
      .in_req   (req_data),
      .win      (win_ff),
      .frac     (frac)
   );

   // Stage E: span check products and offset dividends
   logic                     e_valid_ff, e_reject_ff, e_neg_x_ff, e_neg_y_ff;
   lsc_pkg::req_type         e_req_ff;
   logic [lsc_pkg::PW-1:0]   e_span_en_ff, e_span_ex_ff;
   logic [lsc_pkg::PW-1:0]   e_sx_ff, e_sy_ff, e_ex_ff, e_ey_ff;
   logic [lsc_pkg::DW-1:0]   e_en_den_ff, e_ex_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         e_valid_ff <= frac.valid;
      end
      if (pipe_en) begin
         e_reject_ff  <= frac.reject;
         e_neg_x_ff   <= frac.neg_x;
         e_neg_y_ff   <= frac.neg_y;
         e_req_ff     <= frac.item;
         e_span_en_ff <= frac.en_num * frac.ex_den;
         e_span_ex_ff <= frac.ex_num * frac.en_den;
         e_sx_ff      <= frac.en_num * frac.mag_x;
         e_sy_ff      <= frac.en_num * frac.mag_y;
         e_ex_ff      <= frac.ex_num * frac.mag_x;
         e_ey_ff      <= frac.ex_num * frac.mag_y;
         e_en_den_ff  <= frac.en_den;
         e_ex_den_ff  <= frac.ex_den;
      end
   end

   // Offsets: floor(t * |v|) for both parameters and both axes
   logic [lsc_pkg::QW-1:0] off_sx, off_sy, off_ex, off_ey;

   lsc_div u_div_sx (.clock(clock), .en(pipe_en), .dividend(e_sx_ff),
                     .divisor(e_en_den_ff), .quotient(off_sx));
   lsc_div u_div_sy (.clock(clock), .en(pipe_en), .dividend(e_sy_ff),
                     .divisor(e_en_den_ff), .quotient(off_sy));
   lsc_div u_div_ex (.clock(clock), .en(pipe_en), .dividend(e_ex_ff),
                     .divisor(e_ex_den_ff), .quotient(off_ex));
   lsc_div u_div_ey (.clock(clock), .en(pipe_en), .dividend(e_ey_ff),
                     .divisor(e_ex_den_ff), .quotient(off_ey));

   // Side data alongside the dividers; empty span folds into reject here
   lsc_pkg::side_type side_ff [lsc_pkg::DIV_STAGES];
   lsc_pkg::side_type side_in;
   lsc_pkg::side_type last;

   always_comb begin
      side_in.valid  = e_valid_ff;
      side_in.reject = e_reject_ff | (e_span_en_ff > e_span_ex_ff);
      side_in.neg_x  = e_neg_x_ff;
      side_in.neg_y  = e_neg_y_ff;
      side_in.item   = e_req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lsc_pkg::DIV_STAGES; i++) begin
            side_ff[i] <= '0;
         end
      end else if (pipe_en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < lsc_pkg::DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign last = side_ff[lsc_pkg::DIV_STAGES-1];

   // Result register
   lsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      if (last.reject) begin
         rsp_data_in.visible         = 1'b0;
         rsp_data_in.clipped_start_x = last.item.start_x;
         rsp_data_in.clipped_start_y = last.item.start_y;
         rsp_data_in.clipped_end_x   = last.item.end_x;
         rsp_data_in.clipped_end_y   = last.item.end_y;
      end else begin
         rsp_data_in.visible         = 1'b1;
         rsp_data_in.clipped_start_x = lsc_pkg::place(last.item.start_x, last.neg_x, off_sx);
         rsp_data_in.clipped_start_y = lsc_pkg::place(last.item.start_y, last.neg_y, off_sy);
         rsp_data_in.clipped_end_x   = lsc_pkg::place(last.item.start_x, last.neg_x, off_ex);
         rsp_data_in.clipped_end_y   = lsc_pkg::place(last.item.start_y, last.neg_y, off_ey);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= last.valid;
      end
      if (pipe_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Bounds of the segment for the range check below
   logic signed [lsc_pkg::CW-1:0] min_x, max_x;
   assign min_x = (last.item.start_x < last.item.end_x) ? last.item.start_x : last.item.end_x;
   assign max_x = (last.item.start_x < last.item.end_x) ? last.item.end_x : last.item.start_x;

   // Rejected requests come out invisible with their input coordinates
   assert property (@(posedge clock) disable iff (reset)
      (pipe_en && last.valid && last.reject) |=>
      (rsp_valid && !rsp_data.visible && rsp_data.clipped_end_x == $past(last.item.end_x)))
      else $error("rejected request not passed through");
   // Accepted requests come out visible
   assert property (@(posedge clock) disable iff (reset)
      (pipe_en && last.valid && !last.reject) |=> (rsp_valid && rsp_data.visible))
      else $error("accepted request not visible");
   // The clipped x coordinates stay between the input endpoints
   assert property (@(posedge clock) disable iff (reset)
      (pipe_en && last.valid && !last.reject) |=>
      (rsp_data.clipped_start_x >= $past(min_x) && rsp_data.clipped_start_x <= $past(max_x)
       && rsp_data.clipped_end_x >= $past(min_x) && rsp_data.clipped_end_x <= $past(max_x)))
      else $error("clipped x outside segment");

endmodule

@@ sv/lsc_param.sv @@
// Entry and exit parameter pipeline: edge distances, axis candidates, max/min select.
`timescale 1ns / 1ps

module lsc_param (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  lsc_pkg::req_type     in_req,
   input  lsc_pkg::window_type  win,
   output lsc_pkg::frac_type    frac
);

   // One axis: distances to low and high edge give entry and exit candidates
   function automatic lsc_pkg::axis_type axis_bound(input logic signed [lsc_pkg::DW-1:0] d,
                                                    input logic signed [lsc_pkg::DW-1:0] qlo,
                                                    input logic signed [lsc_pkg::DW-1:0] qhi);
      lsc_pkg::axis_type r;
      logic signed [lsc_pkg::DW-1:0] enq;
      logic signed [lsc_pkg::DW-1:0] exq;
      r.neg    = d < 0;
      r.mag    = (d < 0) ? $unsigned(-d) : $unsigned(d);
      r.en_num = '0;
      r.en_den = lsc_pkg::DW'(1);
      r.ex_num = lsc_pkg::DW'(1);
      r.ex_den = lsc_pkg::DW'(1);
      r.reject = 1'b0;
      if (d > 0) begin
         enq = -qlo;
         exq = qhi;
      end else begin
         enq = -qhi;
         exq = qlo;
      end
      if (d == 0) begin
         r.reject = (qlo < 0) || (qhi < 0);
      end else begin
         if (enq > 0) begin
            r.en_num = $unsigned(enq);
            r.en_den = r.mag;
         end
         if (exq < 0) begin
            r.reject = 1'b1;
         end else if ($unsigned(exq) < r.mag) begin
            r.ex_num = $unsigned(exq);
            r.ex_den = r.mag;
         end
      end
      return r;
   endfunction

   // Stage A: direction and edge distances
   logic                            a_valid_ff, a_valid_in;
   lsc_pkg::req_type                a_req_ff;
   logic signed [lsc_pkg::DW-1:0]   a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic signed [lsc_pkg::DW-1:0]   a_ql_ff, a_qr_ff, a_qb_ff, a_qt_ff;
   logic signed [lsc_pkg::DW-1:0]   a_ql_in, a_qr_in, a_qb_in, a_qt_in;

   assign a_valid_in = in_valid;
   assign a_dx_in = lsc_pkg::sx(in_req.end_x) - lsc_pkg::sx(in_req.start_x);
   assign a_dy_in = lsc_pkg::sx(in_req.end_y) - lsc_pkg::sx(in_req.start_y);
   assign a_ql_in = lsc_pkg::sx(in_req.start_x) - lsc_pkg::sx(win.left);
   assign a_qr_in = lsc_pkg::sx(win.right) - lsc_pkg::sx(in_req.start_x);
   assign a_qb_in = lsc_pkg::sx(in_req.start_y) - lsc_pkg::sx(win.bottom);
   assign a_qt_in = lsc_pkg::sx(win.top) - lsc_pkg::sx(in_req.start_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
      end
      if (en) begin
         a_req_ff <= in_req;
         a_dx_ff  <= a_dx_in;
         a_dy_ff  <= a_dy_in;
         a_ql_ff  <= a_ql_in;
         a_qr_ff  <= a_qr_in;
         a_qb_ff  <= a_qb_in;
         a_qt_ff  <= a_qt_in;
      end
   end

   // Stage B: per-axis candidates
   logic               b_valid_ff;
   lsc_pkg::req_type   b_req_ff;
   lsc_pkg::axis_type  b_x_ff, b_y_ff, b_x_in, b_y_in;

   assign b_x_in = axis_bound(a_dx_ff, a_ql_ff, a_qr_ff);
   assign b_y_in = axis_bound(a_dy_ff, a_qb_ff, a_qt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_req_ff <= a_req_ff;
         b_x_ff   <= b_x_in;
         b_y_ff   <= b_y_in;
      end
   end

   // Stage C: cross products to compare the two axes
   logic                     c_valid_ff;
   lsc_pkg::req_type         c_req_ff;
   lsc_pkg::axis_type        c_x_ff, c_y_ff;
   logic [lsc_pkg::PW-1:0]   c_enx_ff, c_eny_ff, c_exx_ff, c_exy_ff;
   logic [lsc_pkg::PW-1:0]   c_enx_in, c_eny_in, c_exx_in, c_exy_in;

   assign c_enx_in = b_x_ff.en_num * b_y_ff.en_den;
   assign c_eny_in = b_y_ff.en_num * b_x_ff.en_den;
   assign c_exx_in = b_x_ff.ex_num * b_y_ff.ex_den;
   assign c_exy_in = b_y_ff.ex_num * b_x_ff.ex_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
      if (en) begin
         c_req_ff <= b_req_ff;
         c_x_ff   <= b_x_ff;
         c_y_ff   <= b_y_ff;
         c_enx_ff <= c_enx_in;
         c_eny_ff <= c_eny_in;
         c_exx_ff <= c_exx_in;
         c_exy_ff <= c_exy_in;
      end
   end

   // Stage D: entry is the larger fraction, exit the smaller
   lsc_pkg::frac_type  d_frac_ff, d_frac_in;
   logic               d_en_x, d_ex_x;

   assign d_en_x = c_enx_ff > c_eny_ff;
   assign d_ex_x = c_exx_ff < c_exy_ff;

   always_comb begin
      d_frac_in.valid  = c_valid_ff;
      d_frac_in.reject = c_x_ff.reject | c_y_ff.reject;
      d_frac_in.en_num = d_en_x ? c_x_ff.en_num : c_y_ff.en_num;
      d_frac_in.en_den = d_en_x ? c_x_ff.en_den : c_y_ff.en_den;
      d_frac_in.ex_num = d_ex_x ? c_x_ff.ex_num : c_y_ff.ex_num;
      d_frac_in.ex_den = d_ex_x ? c_x_ff.ex_den : c_y_ff.ex_den;
      d_frac_in.mag_x  = c_x_ff.mag;
      d_frac_in.mag_y  = c_y_ff.mag;
      d_frac_in.neg_x  = c_x_ff.neg;
      d_frac_in.neg_y  = c_y_ff.neg;
      d_frac_in.item   = c_req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_frac_ff <= '0;
      end else if (en) begin
         d_frac_ff <= d_frac_in;
      end
   end

   assign frac = d_frac_ff;

   // Exit fraction never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      (en && c_valid_ff) |=> (d_frac_ff.ex_num <= d_frac_ff.ex_den))
      else $error("exit fraction above one");
   // A zero-length axis never offers a crossing
   assert property (@(posedge clock) disable iff (reset)
      (en && a_valid_ff && a_dx_ff == 0) |=> (b_x_ff.en_num == 0))
      else $error("entry candidate on parallel axis");
   // Denominators stay non-zero
   assert property (@(posedge clock) disable iff (reset)
      (en && c_valid_ff) |=> (d_frac_ff.en_den != 0 && d_frac_ff.ex_den != 0))
      else $error("zero denominator");

endmodule

@@ sv/lsc_div.sv @@
// Pipelined restoring divider, a few quotient bits per stage.
`timescale 1ns / 1ps

module lsc_div (
   input  logic                    clock,
   input  logic                    en,
   input  logic [lsc_pkg::PW-1:0]  dividend,
   input  logic [lsc_pkg::DW-1:0]  divisor,
   output logic [lsc_pkg::QW-1:0]  quotient
);

   logic [lsc_pkg::DW-1:0] rem_ff [lsc_pkg::DIV_STAGES];
   logic [lsc_pkg::DW-1:0] den_ff [lsc_pkg::DIV_STAGES];
   logic [lsc_pkg::QW-1:0] low_ff [lsc_pkg::DIV_STAGES];
   logic [lsc_pkg::QW-1:0] quo_ff [lsc_pkg::DIV_STAGES];

   for (genvar s = 0; s < lsc_pkg::DIV_STAGES; s++) begin : g_stage
      logic [lsc_pkg::DW-1:0] rem_src, den_src, rem_in;
      logic [lsc_pkg::QW-1:0] low_src, quo_src, quo_in;

      if (s == 0) begin : g_first
         assign rem_src = lsc_pkg::DW'(dividend[lsc_pkg::PW-1:lsc_pkg::QW]);
         assign low_src = dividend[lsc_pkg::QW-1:0];
         assign quo_src = '0;
         assign den_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign low_src = low_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      // shift in DIV_STEP dividend bits one at a time, subtract when it fits
      always_comb begin : step
         logic [lsc_pkg::DW:0] trial;
         rem_in = rem_src;
         quo_in = quo_src;
         trial  = '0;
         for (int j = 0; j < lsc_pkg::DIV_STEP; j++) begin
            trial = {rem_in, low_src[lsc_pkg::QW-1-s*lsc_pkg::DIV_STEP-j]};
            if (trial >= {1'b0, den_src}) begin
               rem_in = lsc_pkg::DW'(trial - {1'b0, den_src});
               quo_in[lsc_pkg::QW-1-s*lsc_pkg::DIV_STEP-j] = 1'b1;
            end else begin
               rem_in = trial[lsc_pkg::DW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            low_ff[s] <= low_src;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[lsc_pkg::DIV_STAGES-1];

endmodule
